// File: hw/rtl/wal_pkg.sv
`default_nettype none

package wal_pkg;

  // Request kinds carried on the input channel.
  localparam logic [1:0] OP_BEGIN  = 2'd0;
  localparam logic [1:0] OP_END    = 2'd1;
  localparam logic [1:0] OP_WRITE  = 2'd2;
  localparam logic [1:0] OP_DONE   = 2'd3;

  // Result codes carried on the output channel.
  localparam logic [3:0] RC_GRANTED    = 4'd0;
  localparam logic [3:0] RC_REFUSED    = 4'd1;
  localparam logic [3:0] RC_END_PEND   = 4'd2;
  localparam logic [3:0] RC_END_EMPTY  = 4'd3;
  localparam logic [3:0] RC_COPY       = 4'd4;
  localparam logic [3:0] RC_WR_HEADER  = 4'd5;
  localparam logic [3:0] RC_INSTALL    = 4'd6;
  localparam logic [3:0] RC_CLR_HEADER = 4'd7;
  localparam logic [3:0] RC_APPENDED   = 4'd8;
  localparam logic [3:0] RC_ABSORBED   = 4'd9;
  localparam logic [3:0] RC_DIRECT     = 4'd10;
  localparam logic [3:0] RC_LOG_FULL   = 4'd11;
  localparam logic [3:0] RC_UNBALANCED = 4'd12;
  localparam logic [3:0] RC_RELEASED   = 4'd13;

  // Configuration register indexes.
  localparam logic [1:0] CFG_LOG_START = 2'd0;
  localparam logic [1:0] CFG_LOG_SIZE  = 2'd1;
  localparam logic [1:0] CFG_MAX_OP    = 2'd2;

  // Configuration reset values.
  localparam logic [31:0] LOG_START_RST = 32'd2;
  localparam logic [5:0]  LOG_SIZE_RST  = 6'd30;
  localparam logic [4:0]  MAX_OP_RST    = 5'd10;

  // Open operations saturate at this count.
  localparam logic [4:0] OPS_LIMIT = 5'd31;

  // Control from the sequencer to the cell chain.
  typedef struct packed {
    logic shift;
    logic load;
  } wal_chain_ctl_t;

endpackage

`default_nettype wire

// File: hw/rtl/write_ahead_log_manager.sv
`default_nettype none

// Journaling transaction manager with group commit. Requests (begin, end, logged block
// write, commit done) enter one at a time; each answers with one result, except a commit
// done while no commit is busy, which answers with none, and the end that closes the last
// open operation over a non-empty list, which answers with the whole commit run (copies,
// header write, installs, header clear) and marks its final result with tlast. The block
// list sits in a ring of MAX_ENTRIES cells that rotates one place a cycle in a scan, copy
// or install turn, holding while a listed entry waits for the output, with the head cell
// read. A write inside a transaction scans the full ring. A new request is taken while
// the last result still waits in the output register.

module write_ahead_log_manager #(
  parameter int MAX_ENTRIES = 31,
  parameter int BLOCK_BITS  = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input request channel.
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [31:0] block_number
  input  wire logic [1:0]  in_tuser,   // [1:0] operation
  // Result channel.
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [71:0] out_tdata,  // [31:0] source_block, [63:32] dest_block,
                                       // [68:64] header_count, [71:69] zero
  output logic      [3:0]  out_tuser,  // [3:0] result_code
  output logic             out_tlast,
  // Configuration write port.
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_wdata
);

  localparam int AW = (BLOCK_BITS < 32) ? BLOCK_BITS : 32;
  localparam int SW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_APPEND = 3'd3;
  localparam logic [2:0] S_COPY   = 3'd4;
  localparam logic [2:0] S_HDR    = 3'd5;
  localparam logic [2:0] S_INST   = 3'd6;
  localparam logic [2:0] S_CLR    = 3'd7;

  // Configuration registers.
  logic [31:0] log_start_r;
  logic [5:0]  log_size_r;
  logic [4:0]  max_op_r;

  // Control state.
  logic [2:0]    state_r, state_nxt;
  logic [SW-1:0] step_r, step_nxt;
  logic          found_r, found_nxt;
  logic [4:0]    ops_r, ops_nxt;
  logic [CW-1:0] ec_r, ec_nxt;
  logic          busy_r, busy_nxt;
  logic          out_valid_r, out_valid_nxt;

  // Latched request and output payload.
  logic [1:0]    op_r;
  logic [AW-1:0] blk_r;
  logic [3:0]    code_r;
  logic [31:0]   src_r;
  logic [31:0]   dst_r;
  logic [4:0]    cnt_r;
  logic          last_r;

  // Result being formed this cycle.
  logic          emit;
  logic [3:0]    e_code;
  logic [AW-1:0] e_src;
  logic [AW-1:0] e_dst;
  logic [4:0]    e_cnt;
  logic          e_last;

  wal_pkg::wal_chain_ctl_t ctl;
  logic [AW-1:0] head;
  logic          in_acc;
  logic          can_emit;
  logic [5:0]    cap;
  logic [5:0]    cap_raw;
  logic [5:0]    ops_inc;
  logic [10:0]   need;
  logic          refuse;
  logic          in_list;
  logic          step_last;
  logic [AW-1:0] slot_addr;
  logic [AW-1:0] hdr_addr;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign can_emit  = !out_valid_r || out_tready;

  // Usable log entries, capped at the ring length.
  assign cap_raw = (log_size_r == 6'd0) ? 6'd0 : log_size_r - 6'd1;
  assign cap     = (cap_raw > 6'(MAX_ENTRIES)) ? 6'(MAX_ENTRIES) : cap_raw;

  // Worst-case space once one more operation opens.
  assign ops_inc = 6'(ops_r) + 6'd1;
  assign need    = 11'(ec_r) + 11'(ops_inc) * 11'(max_op_r);
  assign refuse  = busy_r || (ops_r == wal_pkg::OPS_LIMIT) || (need > 11'(cap));

  assign in_list   = (CW'(step_r) < ec_r);
  assign step_last = (step_r == SW'(MAX_ENTRIES - 1));
  assign hdr_addr  = log_start_r[AW-1:0];
  assign slot_addr = hdr_addr + AW'(step_r) + AW'(1);

  // Request sequencer.
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    found_nxt = found_r;
    ops_nxt   = ops_r;
    ec_nxt    = ec_r;
    busy_nxt  = busy_r;
    emit      = 1'b0;
    e_code    = wal_pkg::RC_GRANTED;
    e_src     = '0;
    e_dst     = '0;
    e_cnt     = 5'd0;
    e_last    = 1'b1;
    ctl.shift = 1'b0;
    ctl.load  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        case (op_r)
          wal_pkg::OP_BEGIN: begin
            if (can_emit) begin
              emit      = 1'b1;
              state_nxt = S_IDLE;
              if (refuse) begin
                e_code = wal_pkg::RC_REFUSED;
              end else begin
                e_code  = wal_pkg::RC_GRANTED;
                ops_nxt = ops_r + 5'd1;
              end
            end
          end
          wal_pkg::OP_END: begin
            if (ops_r == 5'd0) begin
              if (can_emit) begin
                emit      = 1'b1;
                e_code    = wal_pkg::RC_UNBALANCED;
                state_nxt = S_IDLE;
              end
            end else if (ops_r != 5'd1 || ec_r == '0) begin
              if (can_emit) begin
                emit      = 1'b1;
                e_code    = (ops_r != 5'd1) ? wal_pkg::RC_END_PEND : wal_pkg::RC_END_EMPTY;
                ops_nxt   = ops_r - 5'd1;
                state_nxt = S_IDLE;
              end
            end else begin
              ops_nxt   = 5'd0;
              step_nxt  = '0;
              state_nxt = S_COPY;
            end
          end
          wal_pkg::OP_WRITE: begin
            if (ops_r == 5'd0 || 6'(ec_r) >= cap) begin
              if (can_emit) begin
                emit      = 1'b1;
                e_code    = (ops_r == 5'd0) ? wal_pkg::RC_DIRECT : wal_pkg::RC_LOG_FULL;
                e_src     = blk_r;
                state_nxt = S_IDLE;
              end
            end else begin
              step_nxt  = '0;
              found_nxt = 1'b0;
              state_nxt = S_SCAN;
            end
          end
          wal_pkg::OP_DONE: begin
            if (busy_r) begin
              if (can_emit) begin
                emit      = 1'b1;
                e_code    = wal_pkg::RC_RELEASED;
                busy_nxt  = 1'b0;
                state_nxt = S_IDLE;
              end
            end else begin
              state_nxt = S_IDLE;
            end
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end
      // One full turn of the ring, comparing each listed entry at the head.
      S_SCAN: begin
        ctl.shift = 1'b1;
        if (in_list && head == blk_r) begin
          found_nxt = 1'b1;
        end
        if (step_last) begin
          step_nxt  = '0;
          state_nxt = S_APPEND;
        end else begin
          step_nxt = step_r + SW'(1);
        end
      end
      S_APPEND: begin
        if (can_emit) begin
          emit      = 1'b1;
          e_src     = blk_r;
          state_nxt = S_IDLE;
          if (found_r) begin
            e_code = wal_pkg::RC_ABSORBED;
          end else begin
            e_code   = wal_pkg::RC_APPENDED;
            ctl.load = 1'b1;
            ec_nxt   = ec_r + CW'(1);
          end
        end
      end
      // Copy and install turns: listed entries wait for the output, the rest rotate freely.
      S_COPY, S_INST: begin
        if (!in_list || can_emit) begin
          ctl.shift = 1'b1;
          emit      = in_list;
          e_last    = 1'b0;
          if (state_r == S_COPY) begin
            e_code = wal_pkg::RC_COPY;
            e_src  = head;
            e_dst  = slot_addr;
          end else begin
            e_code = wal_pkg::RC_INSTALL;
            e_src  = slot_addr;
            e_dst  = head;
          end
          if (step_last) begin
            step_nxt  = '0;
            state_nxt = (state_r == S_COPY) ? S_HDR : S_CLR;
          end else begin
            step_nxt = step_r + SW'(1);
          end
        end
      end
      S_HDR: begin
        if (can_emit) begin
          emit      = 1'b1;
          e_code    = wal_pkg::RC_WR_HEADER;
          e_dst     = hdr_addr;
          e_cnt     = 5'(ec_r);
          e_last    = 1'b0;
          state_nxt = S_INST;
        end
      end
      S_CLR: begin
        if (can_emit) begin
          emit      = 1'b1;
          e_code    = wal_pkg::RC_CLR_HEADER;
          e_dst     = hdr_addr;
          ec_nxt    = '0;
          busy_nxt  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output register valid.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      found_r     <= 1'b0;
      ops_r       <= 5'd0;
      ec_r        <= '0;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      found_r     <= found_nxt;
      ops_r       <= ops_nxt;
      ec_r        <= ec_nxt;
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      log_start_r <= wal_pkg::LOG_START_RST;
      log_size_r  <= wal_pkg::LOG_SIZE_RST;
      max_op_r    <= wal_pkg::MAX_OP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        wal_pkg::CFG_LOG_START: log_start_r <= cfg_wdata;
        wal_pkg::CFG_LOG_SIZE:  log_size_r  <= cfg_wdata[5:0];
        wal_pkg::CFG_MAX_OP:    max_op_r    <= cfg_wdata[4:0];
        default: begin
        end
      endcase
    end
  end

  // Request and result payload.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r  <= in_tuser;
      blk_r <= in_tdata[AW-1:0];
    end
    if (emit) begin
      code_r <= e_code;
      src_r  <= 32'(e_src);
      dst_r  <= 32'(e_dst);
      cnt_r  <= e_cnt;
      last_r <= e_last;
    end
  end

  // Block list ring.
  wal_chain #(
    .MAX_ENTRIES(MAX_ENTRIES),
    .AW         (AW),
    .SW         (SW)
  ) u_chain (
    .clk      (clk),
    .ctl      (ctl),
    .load_idx (ec_r[SW-1:0]),
    .load_data(blk_r),
    .head     (head)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'd0, cnt_r, dst_r, src_r};
  assign out_tuser  = code_r;
  assign out_tlast  = last_r;

`ifndef SYNTHESIS
  // The list never holds more entries than the ring has cells.
  a_ec_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ec_r <= CW'(MAX_ENTRIES))
    else $error("entry count beyond ring length");

  // A commit becomes busy only when the header clear is issued.
  a_busy_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy_r) |-> ($past(state_r) == S_CLR && ec_r == '0))
    else $error("commit busy set outside a commit run");

  // A pending grant can never coexist with a busy commit.
  a_grant_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && code_r == wal_pkg::RC_GRANTED) |-> !busy_r)
    else $error("begin granted while a commit is busy");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/wal_cell.sv
`default_nettype none

module wal_cell #(
  parameter int AW = 32
) (
  input  wire logic          clk,
  input  wire logic          shift,
  input  wire logic          load,
  input  wire logic [AW-1:0] shift_in,
  input  wire logic [AW-1:0] load_data,
  output logic      [AW-1:0] entry
);

  logic [AW-1:0] entry_r;
  logic [AW-1:0] entry_nxt;

  // A rotation takes the neighbor's entry; a load takes a new block.
  always_comb begin
    entry_nxt = entry_r;
    if (shift) begin
      entry_nxt = shift_in;
    end else if (load) begin
      entry_nxt = load_data;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;

endmodule

`default_nettype wire

// File: hw/rtl/wal_chain.sv
`default_nettype none

module wal_chain #(
  parameter int MAX_ENTRIES = 31,
  parameter int AW          = 32,
  parameter int SW          = 5
) (
  input  wire logic                    clk,
  input  wire wal_pkg::wal_chain_ctl_t ctl,
  input  wire logic [SW-1:0]           load_idx,
  input  wire logic [AW-1:0]           load_data,
  output logic      [AW-1:0]           head
);

  logic [AW-1:0] entries [MAX_ENTRIES];

  // Ring of cells: each cell takes its upper neighbor, the last wraps to the head.
  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    wal_cell #(
      .AW(AW)
    ) u_cell (
      .clk      (clk),
      .shift    (ctl.shift),
      .load     (ctl.load && (load_idx == SW'(i))),
      .shift_in (entries[(i + 1) % MAX_ENTRIES]),
      .load_data(load_data),
      .entry    (entries[i])
    );
  end

  assign head = entries[0];

endmodule

`default_nettype wire
